// ----- design/rmfb_pkg.sv -----
package rmfb_pkg;

  // Default frame size, in pixels
  localparam int DEFAULT_FRAME_WIDTH  = 400;
  localparam int DEFAULT_FRAME_HEIGHT = 300;

  // Width of the signed coordinate datapath; it covers a 12-bit coordinate
  // plus a span offset and every rotated form for frames up to 2048 pixels.
  localparam int CW = 14;

  localparam logic [7:0] MASK_MSB   = 8'h80;
  localparam logic [7:0] FILL_BLACK = 8'hFF;
  localparam logic [7:0] FILL_WHITE = 8'h00;
  localparam logic [3:0] SPAN_MAX   = 4'd8;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_PIXEL = 2'd1,
    FUNC_SPAN  = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  // Registered result of the pixel address unit
  typedef struct packed {
    logic       in_frame;
    logic [7:0] mask;
  } pix_info_t;

endpackage

// ----- design/rotated_mono_framebuffer_writer.sv -----
// 1-bit-per-pixel frame store with coordinate rotation.
// Input channel (in_valid_i / in_stall_o) takes one operation per transaction:
// clear, set pixel, draw span (up to 8 pixels) or read byte. Output channel
// (out_valid_o / out_stall_i) returns one result per operation: read_data_o
// for a read, clipped_count_o for pixel and span writes.
// Config: cfg_we_i writes the 2-bit rotation; write only while idle.
// Operations run one at a time on a shared pixel address unit (rotate, clip,
// byte index multiply) and a single-port byte memory, so in_stall_o is high
// while an operation is in progress. Each pixel goes through address
// compute, memory read and write back; a clipped pixel skips the write
// back. A span of 0 pixels, and a read at or past the end of the store,
// go straight to the result. A read does one memory read; a clear writes
// one byte a cycle over ROW_BYTES*FRAME_HEIGHT bytes (15000 by default).
// A finished result sits in the output register; the next operation may be
// accepted and computed while it waits, but its result is held back until
// the output register is free. Out-of-range pixels are dropped and counted.
// Reset clears rotation to 0 and empties the output register; the frame
// store content is undefined until a clear or pixel write touches it.
module rotated_mono_framebuffer_writer
  import rmfb_pkg::*;
#(
  parameter int FRAME_WIDTH  = DEFAULT_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEFAULT_FRAME_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic signed [11:0] x_coord_i,
  input  logic signed [11:0] y_coord_i,
  input  logic              color_fg_i,
  input  logic              color_bg_i,
  input  logic [7:0]        pattern_bits_i,
  input  logic [3:0]        span_count_i,
  input  logic [13:0]       read_address_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        read_data_o,
  output logic [3:0]        clipped_count_o
);

  localparam int ROW_BYTES   = (FRAME_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * FRAME_HEIGHT;
  localparam int AW          = $clog2(STORE_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_RD,
    ST_WR,
    ST_CLR,
    ST_RDB,
    ST_RDB_WAIT,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [1:0]           rotation_q;
  logic signed [CW-1:0] cur_x_q, y_q;
  logic [7:0]           pat_q;
  logic [3:0]           cnt_q;
  logic                 fg_q, bg_q;
  logic [3:0]           clip_q;
  logic [7:0]           res_data_q;
  logic [AW-1:0]        raddr_q;
  logic [AW-1:0]        clr_addr_q;
  logic [7:0]           fill_q;
  logic                 out_valid_q;
  logic [7:0]           out_data_q;
  logic [3:0]           out_clip_q;

  logic [AW-1:0]        pix_idx;
  pix_info_t            pix_info;
  logic [AW-1:0]        mem_addr;
  logic                 mem_we;
  logic [7:0]           mem_wdata;
  logic [7:0]           mem_rdata;
  logic                 in_accept;
  logic                 out_free;
  logic                 out_load;
  logic                 read_in_range;
  logic [3:0]           span_len;
  logic                 pix_black;

  assign in_accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || !out_stall_i;
  assign out_load      = (state_q == ST_DONE) && out_free;
  assign read_in_range = {18'd0, read_address_i} < 32'(STORE_BYTES);
  assign span_len      = (span_count_i > SPAN_MAX) ? SPAN_MAX : span_count_i;
  assign pix_black     = pat_q[7] ? fg_q : bg_q;

  rmfb_pixel_addr #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .AW          (AW)
  ) u_pixel_addr (
    .clk_i     (clk_i),
    .en_i      (state_q == ST_CALC),
    .rotation_i(rotation_q),
    .lx_i      (cur_x_q),
    .ly_i      (y_q),
    .idx_o     (pix_idx),
    .info_o    (pix_info)
  );

  always_comb begin
    unique case (state_q)
      ST_RD, ST_WR: mem_addr = pix_idx;
      ST_RDB:       mem_addr = raddr_q;
      ST_CLR:       mem_addr = clr_addr_q;
      default:      mem_addr = '0;
    endcase
  end

  assign mem_we    = (state_q == ST_WR) || (state_q == ST_CLR);
  assign mem_wdata = (state_q == ST_CLR) ? fill_q :
                     pix_black ? (mem_rdata | pix_info.mask) :
                                 (mem_rdata & ~pix_info.mask);

  rmfb_store #(
    .DEPTH(STORE_BYTES),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= ROT_0;
    end else if (cfg_we_i) begin
      rotation_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            cur_x_q    <= CW'(x_coord_i);
            y_q        <= CW'(y_coord_i);
            fg_q       <= color_fg_i;
            bg_q       <= color_bg_i;
            clip_q     <= '0;
            res_data_q <= '0;
            raddr_q    <= AW'(read_address_i);
            clr_addr_q <= '0;
            fill_q     <= color_fg_i ? FILL_BLACK : FILL_WHITE;
            unique case (func_e'(func_i))
              FUNC_CLEAR: state_q <= ST_CLR;
              FUNC_PIXEL: begin
                pat_q   <= MASK_MSB;
                cnt_q   <= 4'd1;
                state_q <= ST_CALC;
              end
              FUNC_SPAN: begin
                pat_q   <= pattern_bits_i;
                cnt_q   <= span_len;
                state_q <= (span_len == 4'd0) ? ST_DONE : ST_CALC;
              end
              default: state_q <= read_in_range ? ST_RDB : ST_DONE;
            endcase
          end
        end
        ST_CALC: state_q <= ST_RD;
        ST_RD, ST_WR: begin
          if ((state_q == ST_RD) && pix_info.in_frame) begin
            state_q <= ST_WR;
          end else begin
            if (!pix_info.in_frame) begin
              clip_q <= clip_q + 4'd1;
            end
            // next pixel of the span
            cur_x_q <= cur_x_q + CW'(1);
            pat_q   <= {pat_q[6:0], 1'b0};
            cnt_q   <= cnt_q - 4'd1;
            state_q <= (cnt_q == 4'd1) ? ST_DONE : ST_CALC;
          end
        end
        ST_CLR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == AW'(STORE_BYTES - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_RDB:      state_q <= ST_RDB_WAIT;
        ST_RDB_WAIT: begin
          res_data_q <= mem_rdata;
          state_q    <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_q  <= res_data_q;
            out_clip_q  <= clip_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_data_q;
  assign clipped_count_o = out_clip_q;

  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (clip_q <= SPAN_MAX))
    else $error("clipped count above span maximum");

  a_write_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) |-> pix_info.in_frame)
    else $error("write back of a clipped pixel");

  a_clear_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> (32'(clr_addr_q) < 32'(STORE_BYTES)))
    else $error("clear sweep past end of store");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_free) |=> (out_valid_o && (state_q == ST_IDLE)))
    else $error("finished operation did not load output register");

endmodule

// ----- design/rmfb_pixel_addr.sv -----
module rmfb_pixel_addr
  import rmfb_pkg::*;
#(
  parameter int FRAME_WIDTH  = DEFAULT_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEFAULT_FRAME_HEIGHT,
  parameter int AW           = 14
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [1:0]           rotation_i,
  input  logic signed [CW-1:0] lx_i,
  input  logic signed [CW-1:0] ly_i,
  output logic [AW-1:0]        idx_o,
  output pix_info_t            info_o
);

  localparam int ROW_BYTES = (FRAME_WIDTH + 7) / 8;
  localparam logic signed [CW-1:0] W_S  = CW'(FRAME_WIDTH);
  localparam logic signed [CW-1:0] H_S  = CW'(FRAME_HEIGHT);
  localparam logic signed [CW-1:0] W1_S = CW'(FRAME_WIDTH - 1);
  localparam logic signed [CW-1:0] H1_S = CW'(FRAME_HEIGHT - 1);

  logic signed [CW-1:0] px, py;
  logic                 inside_d;
  logic [AW-1:0]        idx_d;
  logic [7:0]           mask_d;
  logic [AW-1:0]        idx_q;
  pix_info_t            info_q;

  always_comb begin
    unique case (rot_e'(rotation_i))
      ROT_90: begin
        px = W1_S - ly_i;
        py = lx_i;
      end
      ROT_180: begin
        px = W1_S - lx_i;
        py = H1_S - ly_i;
      end
      ROT_270: begin
        px = ly_i;
        py = H1_S - lx_i;
      end
      default: begin
        px = lx_i;
        py = ly_i;
      end
    endcase
  end

  assign inside_d = (px >= 0) && (px < W_S) && (py >= 0) && (py < H_S);
  // Byte index is only meaningful when the pixel is inside the frame
  assign idx_d    = AW'(px[CW-2:3]) + AW'(py[CW-2:0]) * AW'(ROW_BYTES);
  assign mask_d   = MASK_MSB >> px[2:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q       <= idx_d;
      info_q.in_frame <= inside_d;
      info_q.mask     <= mask_d;
    end
  end

  assign idx_o  = idx_q;
  assign info_o = info_q;

endmodule

// ----- design/rmfb_store.sv -----
module rmfb_store
  import rmfb_pkg::*;
#(
  parameter int DEPTH = DEFAULT_FRAME_HEIGHT * ((DEFAULT_FRAME_WIDTH + 7) / 8),
  parameter int AW    = 14
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
